// File: rtl/core/i2csrm_pkg.sv
// Package for the I2C slave register map: operation codes, address map defaults,
// identity byte table and reset values. No dependencies.
package i2csrm_pkg;

    typedef enum logic [2:0] {
        FN_ADDR   = 3'd0,
        FN_DATA   = 3'd1,
        FN_READ   = 3'd2,
        FN_TICK   = 3'd3,
        FN_LWRITE = 3'd4,
        FN_LREAD  = 3'd5
    } func_t;

    localparam int RW_BASE_DEF  = 64;
    localparam int RW_SIZE_DEF  = 64;
    localparam int RO_SIZE_DEF  = 24;

    localparam int SHARED_DEPTH = 64;
    localparam int SHARED_AW    = $clog2(SHARED_DEPTH);
    localparam int ID_LEN       = 24;

    localparam logic [SHARED_AW-1:0] CMD_OFFSET    = SHARED_AW'(1);
    localparam logic [15:0]          TIMEOUT_RESET = 16'd100;
    localparam logic [15:0]          IDLE_MAX      = 16'hFFFF;

    function automatic logic [7:0] id_byte(input logic [7:0] idx);
        logic [7:0] b;
        case (idx)
            8'd0:    b = 8'h56;
            8'd1:    b = 8'h31;
            8'd2:    b = 8'h2E;
            8'd3:    b = 8'h30;
            8'd4:    b = 8'h30;
            8'd8:    b = 8'h54;
            8'd9:    b = 8'h68;
            8'd10:   b = 8'h69;
            8'd11:   b = 8'h6E;
            8'd12:   b = 8'h6B;
            8'd13:   b = 8'h44;
            8'd14:   b = 8'h49;
            8'd15:   b = 8'h59;
            8'd16:   b = 8'h41;
            8'd17:   b = 8'h72;
            8'd18:   b = 8'h64;
            8'd19:   b = 8'h75;
            8'd20:   b = 8'h53;
            8'd21:   b = 8'h4F;
            8'd22:   b = 8'h43;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/i2c_slave_register_map_top.sv
// Top level of the I2C slave register map: pointer, link timeout, illegal record
// and the shared byte memory. Depends on i2csrm_pkg.
//
// Usage:
// - s_ channel carries one word per bus or local event (func, byte_value,
//   local_offset); m_ channel returns one result word per input word.
// - cfg_ channel writes the 16-bit idle timeout; cfg_ready is always high.
// - An accepted word waits in the input register and is executed from it once
//   the output register can take its result (pointer/state update, at most one
//   shared memory access); its result leaves from the output register.
// - Throughput is one word per cycle while m_ready stays high; the single-port
//   shared memory is touched at most once per word.
// - A stalled m_ready holds the result and the executing word; s_ready drops
//   once the input register is also full.
// - Reset clears the pointer, link state, illegal record and the per-entry
//   valid bits of the shared memory, so unwritten bytes read as zero; no
//   clearing pass is needed.
module i2c_slave_register_map_top #(
    parameter int RW_BASE = i2csrm_pkg::RW_BASE_DEF,
    parameter int RW_SIZE = i2csrm_pkg::RW_SIZE_DEF,
    parameter int RO_SIZE = i2csrm_pkg::RO_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_byte_value,
    input  logic [5:0]  s_local_offset,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid,
    output logic        m_alive,
    output logic        m_illegal_flag,
    output logic [7:0]  m_last_illegal_address
);

    localparam int                AW      = i2csrm_pkg::SHARED_AW;
    localparam logic [7:0]        BASE_B  = 8'(RW_BASE);
    localparam logic [7:0]        SIZE_B  = 8'(RW_SIZE);
    localparam logic [7:0]        ROSZ_B  = 8'(RO_SIZE);

    logic [15:0] timeout_reg;

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [7:0]  in_byte_reg;
    logic [5:0]  in_off_reg;

    logic [7:0]  ptr_reg, ptr_next;
    logic        alive_reg, alive_next;
    logic        act_reg, act_next;
    logic [15:0] idle_reg, idle_next;
    logic        drx_reg, drx_next;
    logic [7:0]  bad_addr_reg, bad_addr_next;
    logic        bad_reg, bad_next;

    logic        m_valid_reg;
    logic        out_rdv_reg, rdv_next;
    logic        out_mem_reg, rmem_next;
    logic [7:0]  out_byte_reg, rbyte_next;
    logic        out_alive_reg;
    logic        out_bad_reg;
    logic [7:0]  out_bad_addr_reg;

    logic [7:0]  mem [i2csrm_pkg::SHARED_DEPTH];
    logic [i2csrm_pkg::SHARED_DEPTH-1:0] ent_valid_reg;
    logic [7:0]  rdata_reg;
    logic        ent_ok_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata;

    logic          advance;
    logic          in_rw, in_shared, loc_ok;
    logic [7:0]    rw_off;
    logic [15:0]   idle_inc;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= i2csrm_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_byte_value;
            in_off_reg  <= s_local_offset;
        end
    end

    assign rw_off    = ptr_reg - BASE_B;
    assign in_rw     = ptr_reg >= BASE_B;
    assign in_shared = in_rw && (rw_off < SIZE_B);
    assign loc_ok    = {2'b00, in_off_reg} < SIZE_B;
    assign idle_inc  = (idle_reg != i2csrm_pkg::IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;

    always_comb begin
        ptr_next      = ptr_reg;
        alive_next    = alive_reg;
        act_next      = act_reg;
        idle_next     = idle_reg;
        drx_next      = drx_reg;
        bad_addr_next = bad_addr_reg;
        bad_next      = bad_reg;
        rdv_next      = 1'b0;
        rmem_next     = 1'b0;
        rbyte_next    = 8'h00;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = rw_off[AW-1:0];
        mem_raddr     = rw_off[AW-1:0];
        mem_wdata     = in_byte_reg;
        case (i2csrm_pkg::func_t'(in_func_reg))
            i2csrm_pkg::FN_ADDR: begin
                if (!alive_reg) begin
                    alive_next = 1'b1;
                    act_next   = 1'b1;
                end
                ptr_next = in_byte_reg;
            end
            i2csrm_pkg::FN_DATA: begin
                if (!alive_reg) begin
                    alive_next = 1'b1;
                    act_next   = 1'b1;
                end
                if (!in_rw) begin
                    bad_addr_next = ptr_reg;
                    bad_next      = 1'b1;
                end else begin
                    act_next = 1'b1;
                    if (in_shared) begin
                        mem_we   = 1'b1;
                        drx_next = 1'b1;
                        ptr_next = ptr_reg + 8'd1;
                    end else begin
                        bad_addr_next = ptr_reg;
                        bad_next      = 1'b1;
                    end
                end
            end
            i2csrm_pkg::FN_READ: begin
                if (!alive_reg) begin
                    rdv_next = 1'b1;
                end else begin
                    act_next = 1'b1;
                    if (!in_rw) begin
                        if (ptr_reg < ROSZ_B) begin
                            rdv_next   = 1'b1;
                            rbyte_next = i2csrm_pkg::id_byte(ptr_reg);
                        end
                        ptr_next = ptr_reg + 8'd1;
                    end else if (in_shared) begin
                        rdv_next  = 1'b1;
                        rmem_next = 1'b1;
                        mem_re    = 1'b1;
                        ptr_next  = ptr_reg + 8'd1;
                    end
                end
            end
            i2csrm_pkg::FN_TICK: begin
                if (alive_reg) begin
                    if (act_reg) begin
                        idle_next = 16'd0;
                        act_next  = 1'b0;
                    end else if (idle_inc > timeout_reg) begin
                        alive_next = 1'b0;
                        ptr_next   = 8'd0;
                        idle_next  = 16'd0;
                    end else begin
                        idle_next = idle_inc;
                    end
                    if (drx_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = i2csrm_pkg::CMD_OFFSET;
                        mem_wdata = 8'h00;
                    end
                end
                drx_next = 1'b0;
            end
            i2csrm_pkg::FN_LWRITE: begin
                if (loc_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = in_off_reg[AW-1:0];
                end
            end
            i2csrm_pkg::FN_LREAD: begin
                if (loc_ok) begin
                    rdv_next  = 1'b1;
                    rmem_next = 1'b1;
                    mem_re    = 1'b1;
                    mem_raddr = in_off_reg[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg      <= 8'd0;
            alive_reg    <= 1'b0;
            act_reg      <= 1'b0;
            idle_reg     <= 16'd0;
            drx_reg      <= 1'b0;
            bad_addr_reg <= 8'd0;
            bad_reg      <= 1'b0;
        end else if (advance) begin
            ptr_reg      <= ptr_next;
            alive_reg    <= alive_next;
            act_reg      <= act_next;
            idle_reg     <= idle_next;
            drx_reg      <= drx_next;
            bad_addr_reg <= bad_addr_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (advance && mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (advance && mem_we) begin
            ent_valid_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && mem_re) begin
            ent_ok_reg <= ent_valid_reg[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rdv_reg      <= rdv_next;
            out_mem_reg      <= rmem_next;
            out_byte_reg     <= rbyte_next;
            out_alive_reg    <= alive_next;
            out_bad_reg      <= bad_next;
            out_bad_addr_reg <= bad_addr_next;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_read_valid           = out_rdv_reg;
    assign m_read_data            = out_mem_reg ? (rdata_reg & {8{ent_ok_reg}}) : out_byte_reg;
    assign m_alive                = out_alive_reg;
    assign m_illegal_flag         = out_bad_reg;
    assign m_last_illegal_address = out_bad_addr_reg;

    a_mem_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("shared memory read and write in one word");

    a_data_zero_when_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_read_valid |-> m_read_data == 8'h00)
        else $error("read data nonzero without read_valid");

    a_illegal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        bad_reg |=> bad_reg)
        else $error("illegal record cleared");

    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(alive_reg) |-> ptr_reg == 8'd0 && idle_reg == 16'd0)
        else $error("link timeout left pointer or idle count set");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !advance)
        else $error("word executed while result stalled");

endmodule
